// ----- src/haversine_distance_top_defines.svh -----
// ----------------------------------------------------------------------------
// Haversine distance assertion macros
// Shared concurrent assertion forms for the haversine distance block.
// ----------------------------------------------------------------------------
`ifndef HAVERSINE_DISTANCE_TOP_DEFINES_SVH
`define HAVERSINE_DISTANCE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define HVD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define HVD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/hvd_pkg.sv -----
// ----------------------------------------------------------------------------
// Haversine distance package
// Shared types, constants and the CORDIC angle table.
// ----------------------------------------------------------------------------
package hvd_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 31;
    // Input, three phase stages, rotation chain, three product stages,
    // square root chain, vectoring chain, two scaling stages.
    localparam int PIPE_DEPTH   = 4 + CORDIC_STEPS + 3 + SQRT_STEPS + CORDIC_STEPS + 2;
    // Index of the valid bit that goes with the clamped haversine value.
    localparam int H_STAGE      = 3 + CORDIC_STEPS + 3;

    typedef logic signed [32:0] cordic_word_t;

    typedef struct packed {
        logic [4:0] step;
        logic       vectoring;
    } cordic_ctl_t;

    localparam logic [15:0]  RADIUS_RESET = 16'd6371;
    localparam cordic_word_t CORDIC_GAIN  = 33'sd652032874;
    localparam logic [30:0]  QONE         = 31'h4000_0000;
    localparam logic [31:0]  PI_Q30       = 32'hC90F_DAA2;
    localparam logic [31:0]  DIV45_RECIP  = 32'd3054198967;
    localparam logic [13:0]  DIV45_SMALL  = 14'd11651;
    localparam logic [12:0]  ROUND_HALF   = 13'd22;

    // atan(2^-i) in 2^-32 turns.
    function automatic cordic_word_t atan_angle(input logic [4:0] step);
        cordic_word_t a;
        case (step)
            5'd0:    a = 33'sd536870912;
            5'd1:    a = 33'sd316933406;
            5'd2:    a = 33'sd167458907;
            5'd3:    a = 33'sd85004756;
            5'd4:    a = 33'sd42667331;
            5'd5:    a = 33'sd21354465;
            5'd6:    a = 33'sd10679838;
            5'd7:    a = 33'sd5340245;
            5'd8:    a = 33'sd2670163;
            5'd9:    a = 33'sd1335087;
            5'd10:   a = 33'sd667544;
            5'd11:   a = 33'sd333772;
            5'd12:   a = 33'sd166886;
            5'd13:   a = 33'sd83443;
            5'd14:   a = 33'sd41722;
            5'd15:   a = 33'sd20861;
            5'd16:   a = 33'sd10430;
            5'd17:   a = 33'sd5215;
            5'd18:   a = 33'sd2608;
            5'd19:   a = 33'sd1304;
            5'd20:   a = 33'sd652;
            5'd21:   a = 33'sd326;
            5'd22:   a = 33'sd163;
            5'd23:   a = 33'sd81;
            5'd24:   a = 33'sd41;
            5'd25:   a = 33'sd20;
            5'd26:   a = 33'sd10;
            5'd27:   a = 33'sd5;
            5'd28:   a = 33'sd3;
            5'd29:   a = 33'sd1;
            default: a = 33'sd0;
        endcase
        return a;
    endfunction

endpackage

// ----- src/haversine_distance_top.sv -----
// ----------------------------------------------------------------------------
// Haversine distance top level
// The done strobe marks each result as it leaves the end of the pipeline.
// Throughput: one point pair per cycle; busy stays low, so start is always taken.
// The pipeline depth is set by the cell chains: 30 rotation cells, 31 square root
// cells and 30 vectoring cells, plus nine arithmetic stages.
// Reset clears the valid pipeline and loads the radius with 6371 km.
// ----------------------------------------------------------------------------
`include "haversine_distance_top_defines.svh"

module haversine_distance_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [29:0] first_latitude,
    input  logic signed [30:0] first_longitude,
    input  logic signed [29:0] second_latitude,
    input  logic signed [30:0] second_longitude,
    output logic               done,
    output logic [31:0]        distance,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        sphere_radius_km
);

    localparam int NC = hvd_pkg::CORDIC_STEPS;
    localparam int NS = hvd_pkg::SQRT_STEPS;

    logic                              accept;
    logic [hvd_pkg::PIPE_DEPTH-1:0]    vld_reg, vld_next;
    logic [15:0]                       radius_reg;

    logic [30:0] mag_a [4];
    logic [30:0] m_reg [4];
    logic [30:0] mb_reg [4];
    logic [25:0] q_reg [4];
    logic [25:0] qc_reg [4];
    logic [12:0] x_reg [4];
    logic [31:0] phase_reg [4];

    hvd_pkg::cordic_word_t rx [4][NC+1];
    hvd_pkg::cordic_word_t ry [4][NC+1];
    hvd_pkg::cordic_word_t rz [4][NC+1];
    logic [1:0]            rt [4][NC+1];

    logic signed [31:0] sn_reg [2];
    logic signed [31:0] cs_reg [2];
    logic [30:0]        u2_reg, v2_reg, v2_next, u2_next;
    logic signed [31:0] cc_reg, cc_next;
    logic [30:0]        h_reg, h_next;

    logic [60:0] sa_rem [NS+1];
    logic [30:0] sa_root [NS+1];
    logic [60:0] sb_rem [NS+1];
    logic [30:0] sb_root [NS+1];

    hvd_pkg::cordic_word_t vx [NC+1];
    hvd_pkg::cordic_word_t vy [NC+1];
    hvd_pkg::cordic_word_t vz [NC+1];
    logic [1:0]            vt [NC+1];

    logic [42:0] p_reg, p_next;
    logic [31:0] dist_reg, dist_next;

    assign accept    = start && !busy;
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Radius register, written by a configuration transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= hvd_pkg::RADIUS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            radius_reg <= sphere_radius_km;
        end
    end

    // Valid bits follow each item through every stage.
    assign vld_next = {vld_reg[hvd_pkg::PIPE_DEPTH-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Magnitudes of the latitude and longitude differences and of the two latitudes.
    always_comb
    begin
        logic signed [30:0] dlat;
        logic signed [31:0] dlon;
        dlat = 31'(second_latitude) - 31'(first_latitude);
        dlon = 32'(second_longitude) - 32'(first_longitude);
        mag_a[0] = dlat[30] ? 31'(-dlat) : 31'(dlat);
        mag_a[1] = dlon[31] ? 31'(-dlon) : 31'(dlon);
        mag_a[2] = first_latitude[29] ? 31'(-31'(first_latitude)) : 31'(first_latitude);
        mag_a[3] = second_latitude[29] ? 31'(-31'(second_latitude))
                                       : 31'(second_latitude);
    end

    // Per lane: phase = round(m * 2^k / 360), then the sine/cosine chain.
    for (genvar l = 0; l < 4; l++)
    begin : g_lane
        localparam int SH = (l < 2) ? 6 : 7;

        logic [62:0] qprod;
        logic [30:0] rfull;
        logic [26:0] sprod;

        assign qprod = 63'(m_reg[l]) * 63'(hvd_pkg::DIV45_RECIP);
        assign rfull = mb_reg[l] - 31'(q_reg[l] * 31'd45);
        assign sprod = 27'(x_reg[l]) * 27'(hvd_pkg::DIV45_SMALL);

        // Split m by 45, then round the scaled remainder by a small reciprocal.
        always_ff @(posedge clk)
        begin
            m_reg[l]     <= mag_a[l];
            q_reg[l]     <= qprod[62:37];
            mb_reg[l]    <= m_reg[l];
            x_reg[l]     <= (13'(rfull[5:0]) << SH) + hvd_pkg::ROUND_HALF;
            qc_reg[l]    <= q_reg[l];
            phase_reg[l] <= (32'(qc_reg[l]) << SH) + 32'(sprod[25:19]);
        end

        assign rx[l][0] = hvd_pkg::CORDIC_GAIN;
        assign ry[l][0] = '0;
        assign rz[l][0] = 33'(phase_reg[l][29:0]);
        assign rt[l][0] = phase_reg[l][31:30];

        for (genvar i = 0; i < NC; i++)
        begin : g_rot
            hvd_pkg::cordic_ctl_t ctl;
            assign ctl.step      = 5'(i);
            assign ctl.vectoring = 1'b0;

            hvd_cordic_cell u_cell
            (
                .clk     (clk),
                .ctl     (ctl),
                .x_in    (rx[l][i]),
                .y_in    (ry[l][i]),
                .z_in    (rz[l][i]),
                .tag_in  (rt[l][i]),
                .x_out   (rx[l][i+1]),
                .y_out   (ry[l][i+1]),
                .z_out   (rz[l][i+1]),
                .tag_out (rt[l][i+1])
            );
        end
    end

    // Clamp to the first quadrant and map back: sines of lanes 0-1, cosines of 2-3.
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 4; l++)
        begin
            logic [30:0]        cx, cy;
            logic signed [31:0] px, py, s, c;
            cx = rx[l][NC][32] ? 31'd0
               : (rx[l][NC] > 33'(hvd_pkg::QONE)) ? hvd_pkg::QONE : rx[l][NC][30:0];
            cy = ry[l][NC][32] ? 31'd0
               : (ry[l][NC] > 33'(hvd_pkg::QONE)) ? hvd_pkg::QONE : ry[l][NC][30:0];
            px = 32'(cx);
            py = 32'(cy);
            case (rt[l][NC])
                2'd0:    begin c = px;  s = py;  end
                2'd1:    begin c = -py; s = px;  end
                2'd2:    begin c = -px; s = -py; end
                default: begin c = py;  s = -px; end
            endcase
            if (l < 2)
            begin
                sn_reg[l[0]] <= s;
            end
            else
            begin
                cs_reg[l[0]] <= c;
            end
        end
    end

    // Squares of the half-angle sines and the cosine product.
    always_comb
    begin
        logic signed [63:0] pu, pv, pc;
        pu      = 64'(sn_reg[0]) * 64'(sn_reg[0]);
        pv      = 64'(sn_reg[1]) * 64'(sn_reg[1]);
        pc      = 64'(cs_reg[0]) * 64'(cs_reg[1]);
        u2_next = pu[60:30];
        v2_next = pv[60:30];
        cc_next = pc[61:30];
    end

    // Haversine sum, clamped to [0, 1].
    always_comb
    begin
        logic signed [63:0] pt;
        logic signed [32:0] sum;
        pt  = 64'(cc_reg) * 64'($signed({1'b0, v2_reg}));
        sum = 33'($signed({1'b0, u2_reg})) + 33'($signed(pt[61:30]));
        if (sum[32])
        begin
            h_next = '0;
        end
        else if (sum > 33'(hvd_pkg::QONE))
        begin
            h_next = hvd_pkg::QONE;
        end
        else
        begin
            h_next = sum[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        u2_reg <= u2_next;
        v2_reg <= v2_next;
        cc_reg <= cc_next;
        h_reg  <= h_next;
    end

    // Square roots of h and 1-h, one root bit per cell.
    assign sa_rem[0]  = {h_reg, 30'd0};
    assign sa_root[0] = '0;
    assign sb_rem[0]  = {hvd_pkg::QONE - h_reg, 30'd0};
    assign sb_root[0] = '0;

    for (genvar j = 0; j < NS; j++)
    begin : g_sqrt
        logic [4:0] k;
        assign k = 5'(NS - 1 - j);

        hvd_sqrt_cell u_sa
        (
            .clk      (clk),
            .step     (k),
            .rem_in   (sa_rem[j]),
            .root_in  (sa_root[j]),
            .rem_out  (sa_rem[j+1]),
            .root_out (sa_root[j+1])
        );

        hvd_sqrt_cell u_sb
        (
            .clk      (clk),
            .step     (k),
            .rem_in   (sb_rem[j]),
            .root_in  (sb_root[j]),
            .rem_out  (sb_rem[j+1]),
            .root_out (sb_root[j+1])
        );
    end

    // Vectoring chain: atan2(sqrt(h), sqrt(1-h)) is the half central angle.
    assign vx[0] = 33'(sb_root[NS]);
    assign vy[0] = 33'(sa_root[NS]);
    assign vz[0] = '0;
    assign vt[0] = '0;

    for (genvar i = 0; i < NC; i++)
    begin : g_vec
        hvd_pkg::cordic_ctl_t ctl;
        assign ctl.step      = 5'(i);
        assign ctl.vectoring = 1'b1;

        hvd_cordic_cell u_cell
        (
            .clk     (clk),
            .ctl     (ctl),
            .x_in    (vx[i]),
            .y_in    (vy[i]),
            .z_in    (vz[i]),
            .tag_in  (vt[i]),
            .x_out   (vx[i+1]),
            .y_out   (vy[i+1]),
            .z_out   (vz[i+1]),
            .tag_out (vt[i+1])
        );
    end

    // Turns to radians, then scale by the radius with saturation.
    always_comb
    begin
        logic [30:0] zc;
        logic [62:0] pp;
        logic [58:0] dp;
        zc = vz[NC][32] ? 31'd0
           : (vz[NC] > 33'(hvd_pkg::QONE)) ? hvd_pkg::QONE : vz[NC][30:0];
        pp = 63'(zc) * 63'(hvd_pkg::PI_Q30);
        p_next = pp[62:20];
        dp = 59'(p_reg) * 59'(radius_reg);
        dist_next = (dp[58:56] != 3'd0) ? 32'hFFFF_FFFF : dp[55:24];
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        dist_reg <= dist_next;
    end

    assign done     = vld_reg[hvd_pkg::PIPE_DEPTH-1];
    assign distance = dist_reg;

    // Checks on the pipeline.
    `HVD_ASSERT_SAME(a_done_has_start, done, $past(start, hvd_pkg::PIPE_DEPTH), "done without a start transfer")
    `HVD_ASSERT_SAME(a_zero_radius, done && (radius_reg == 16'd0), distance == 32'd0, "nonzero distance at zero radius")
    `HVD_ASSERT_NEXT(a_h_clamped, vld_reg[hvd_pkg::H_STAGE-1], h_reg <= hvd_pkg::QONE, "haversine value above one")

endmodule

// ----- src/hvd_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// Haversine distance CORDIC cell
// One registered micro-rotation, in rotation or vectoring mode.
// ----------------------------------------------------------------------------
module hvd_cordic_cell
(
    input  logic                 clk,
    input  hvd_pkg::cordic_ctl_t ctl,
    input  hvd_pkg::cordic_word_t x_in,
    input  hvd_pkg::cordic_word_t y_in,
    input  hvd_pkg::cordic_word_t z_in,
    input  logic [1:0]           tag_in,
    output hvd_pkg::cordic_word_t x_out,
    output hvd_pkg::cordic_word_t y_out,
    output hvd_pkg::cordic_word_t z_out,
    output logic [1:0]           tag_out
);

    hvd_pkg::cordic_word_t x_reg, y_reg, z_reg;
    hvd_pkg::cordic_word_t x_next, y_next, z_next;
    hvd_pkg::cordic_word_t dx, dy, ang;
    logic [1:0]            tag_reg;
    logic                  cw;

    // A negative residual angle and a non-negative vector y both turn clockwise.
    always_comb
    begin
        dx  = y_in >>> ctl.step;
        dy  = x_in >>> ctl.step;
        ang = hvd_pkg::atan_angle(ctl.step);
        cw  = ctl.vectoring ? !y_in[32] : z_in[32];
        if (cw)
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ang;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ang;
        end
    end

    // Hand the rotated vector to the next cell.
    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        tag_reg <= tag_in;
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
    assign tag_out = tag_reg;

endmodule

// ----- src/hvd_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// Haversine distance square root cell
// Decides one root bit of a floor square root and passes the remainder on.
// ----------------------------------------------------------------------------
module hvd_sqrt_cell
(
    input  logic        clk,
    input  logic [4:0]  step,
    input  logic [60:0] rem_in,
    input  logic [30:0] root_in,
    output logic [60:0] rem_out,
    output logic [30:0] root_out
);

    logic [60:0] rem_reg, rem_next;
    logic [30:0] root_reg, root_next;
    logic [62:0] delta;

    // Setting bit k grows the square by root*2^(k+1) + 2^(2k).
    always_comb
    begin
        delta = (63'(root_in) << (step + 5'd1)) + (63'(1) << {step, 1'b0});
        if (63'(rem_in) >= delta)
        begin
            rem_next  = rem_in - delta[60:0];
            root_next = root_in | (31'(1) << step);
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in;
        end
    end

    // Hand the partial root to the next cell.
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule
